### hdl/oaids_pkg.sv
// ---------------------------------------------------------------------------
// oaids_pkg - shared types for the ordered array list
// Operation and status codes, and the control word broadcast to each cell.
// ---------------------------------------------------------------------------
package oaids_pkg;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_SEARCH = 2'd2
	} func_e_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_MISSING  = 2'd3
	} status_e_t;

	// qualified operation, broadcast to every cell in the cycle a word is taken
	typedef struct packed {
		logic load;
		logic ins;
		logic del;
		logic srch;
	} cell_ctrl_t;

endpackage

### hdl/oaids_cell.sv
// ---------------------------------------------------------------------------
// oaids_cell - one list entry
// Holds one entry, shifts from its neighbours on insert and delete, and
// registers an equality match against the search word.
// ---------------------------------------------------------------------------
module oaids_cell import oaids_pkg::*; #(
	parameter int WORD_WIDTH = 32,
	parameter int PW         = 5,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [PW-1:0]         pos,
	input  logic [PW-1:0]         len,
	input  logic [WORD_WIDTH-1:0] word,
	input  logic [WORD_WIDTH-1:0] left,
	input  logic [WORD_WIDTH-1:0] right,
	output logic [WORD_WIDTH-1:0] entry,
	output logic                  match
);

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	logic [WORD_WIDTH-1:0] entry_q;
	logic                  match_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_IDX == pos) begin
				entry_q <= word;
			end else if (MY_IDX > pos) begin
				entry_q <= left;
			end
		end else if (ctrl.del && (MY_IDX >= pos)) begin
			entry_q <= right;
		end
	end

	// only entries below the pre-operation count take part in a search
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			match_q <= ctrl.srch && (entry_q == word) && (MY_IDX < len);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

### hdl/ordered_array_insert_delete_search_top.sv
// ---------------------------------------------------------------------------
// ordered_array_insert_delete_search_top - dense list with insert/delete/search
// A row of cells holds the list; each operation updates all cells at once.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one operation word: func, pos and
//   value. Output channel (out_valid/out_stall) gives one result word per
//   operation: status, index and the entry count after the operation.
//   A word is accepted on a rising edge with valid high and stall low.
//   Insert and delete shift the cells at and above pos in the edge the word
//   is taken; search registers a match bit in every cell in that edge, and the
//   lowest matching cell is picked into the output register on advance.
//   Each word is registered in the search stage and then in the output
//   register, where out_valid rises. Throughput: one operation per cycle while
//   out_stall is low, set by the single shift/compare step in the cells.
//   When out_stall is held the output register and the search stage fill,
//   then in_stall rises; nothing is dropped.
//   Reset clears the entry count and both valid flags; entry contents are
//   undefined until written and are never read before that.
// ---------------------------------------------------------------------------
module ordered_array_insert_delete_search_top import oaids_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   func,
	input  logic [$clog2(DEPTH+1)-1:0]   pos,
	input  logic signed [31:0]           value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [$clog2(DEPTH)-1:0]     index,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [63:0]           value_ext;
	logic [WORD_WIDTH-1:0] word;
	logic                  accept;
	logic                  advance;
	logic                  out_free;
	logic                  pos_ins_ok;
	logic                  pos_del_ok;
	logic                  full;
	cell_ctrl_t            ctrl;
	status_e_t             status_d;
	logic [CW-1:0]         length_d;

	logic [CW-1:0]         length_q;

	logic                  valid_s1;
	logic                  srch_s1;
	status_e_t             status_s1;
	logic [CW-1:0]         count_s1;

	logic                  out_valid_q;
	status_e_t             status_q;
	logic [IW-1:0]         index_q;
	logic [CW-1:0]         count_q;

	logic [WORD_WIDTH-1:0] entry_w [DEPTH];
	logic [DEPTH-1:0]      match_w;
	logic                  hit;
	logic [IW-1:0]         first_idx;

	// sign-extend, then keep the stored width
	assign value_ext = {{32{value[31]}}, value};
	assign word      = value_ext[WORD_WIDTH-1:0];

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	assign pos_ins_ok = (pos <= length_q);
	assign pos_del_ok = (pos < length_q);
	assign full       = (length_q == CW'(DEPTH));

	always_comb begin
		ctrl      = '0;
		ctrl.load = accept;
		status_d  = ST_BADPOS;
		length_d  = length_q;
		case (func_e_t'(func))
			FUNC_INSERT: begin
				if (!pos_ins_ok) begin
					status_d = ST_BADPOS;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_OK;
					ctrl.ins = accept;
					length_d = length_q + CW'(1);
				end
			end
			FUNC_DELETE: begin
				if (pos_del_ok) begin
					status_d = ST_OK;
					ctrl.del = accept;
					length_d = length_q - CW'(1);
				end
			end
			FUNC_SEARCH: begin
				status_d  = ST_MISSING;
				ctrl.srch = accept;
			end
			default: begin
				status_d = ST_BADPOS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				length_q <= length_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			srch_s1   <= ctrl.srch;
			status_s1 <= status_d;
			count_s1  <= length_d;
		end
	end

	genvar k;
	generate
		for (k = 0; k < DEPTH; k++) begin : g_cell
			logic [WORD_WIDTH-1:0] left_w;
			logic [WORD_WIDTH-1:0] right_w;
			if (k == 0) begin : g_first
				assign left_w = word;
			end else begin : g_mid_l
				assign left_w = entry_w[k-1];
			end
			if (k == DEPTH - 1) begin : g_last
				assign right_w = entry_w[k];
			end else begin : g_mid_r
				assign right_w = entry_w[k+1];
			end
			oaids_cell #(
				.WORD_WIDTH (WORD_WIDTH),
				.PW         (CW),
				.IDX        (k)
			) u_cell (
				.clk   (clk),
				.ctrl  (ctrl),
				.pos   (pos),
				.len   (length_q),
				.word  (word),
				.left  (left_w),
				.right (right_w),
				.entry (entry_w[k]),
				.match (match_w[k])
			);
		end
	endgenerate

	// lowest matching cell wins
	always_comb begin
		hit       = |match_w;
		first_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_w[i]) begin
				first_idx = IW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			count_q <= count_s1;
			if (srch_s1 && hit) begin
				status_q <= ST_OK;
				index_q  <= first_idx;
			end else begin
				status_q <= status_s1;
				index_q  <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign index     = index_q;
	assign count     = count_q;

`ifndef ASSERT_OFF
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_ctrl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.ins, ctrl.del, ctrl.srch}))
		else $error("more than one operation broadcast");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> length_q == $past(length_q) + CW'(1))
		else $error("insert did not grow the list");

	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> index_q == '0)
		else $error("index set on a failed operation");
`endif

endmodule
